/* rtl/spq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  // Queue geometry and priority range
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned PRIO_CEIL   = 255;
  localparam int unsigned PRIO_FLOOR  = 0;

  // Beat field widths
  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned PAYLOAD_W = 32;
  localparam int unsigned REQ_W     = 8;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned OCC_W     = 5;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_PRIO = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_HEAD = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TAIL = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_GET  = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    SPQ_OP_HOLD,
    SPQ_OP_PRIO,
    SPQ_OP_HEAD,
    SPQ_OP_TAIL,
    SPQ_OP_POP
  } spq_op_e;

  typedef struct packed {
    logic [ACTION_W-1:0]  action;
    logic [PAYLOAD_W-1:0] payload;
    logic [REQ_W-1:0]     priority_req;
  } spq_in_t;

  typedef struct packed {
    logic [PAYLOAD_W-1:0] out_payload;
    logic [STATUS_W-1:0]  status;
    logic [OCC_W-1:0]     occupancy;
  } spq_out_t;

endpackage

`default_nettype wire

/* rtl/spq_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module spq_cell import spq_pkg::*; #(
  parameter int unsigned PrioW = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire spq_op_e              op_i,
  input  wire logic [PrioW-1:0]     new_prio_i,
  input  wire logic [PAYLOAD_W-1:0] new_payload_i,
  input  wire logic                 left_keep_i,
  input  wire logic                 left_valid_i,
  input  wire logic [PrioW-1:0]     left_prio_i,
  input  wire logic [PAYLOAD_W-1:0] left_payload_i,
  input  wire logic                 right_valid_i,
  input  wire logic [PrioW-1:0]     right_prio_i,
  input  wire logic [PAYLOAD_W-1:0] right_payload_i,
  output logic                      keep_o,
  output logic                      valid_o,
  output logic [PrioW-1:0]          prio_o,
  output logic [PAYLOAD_W-1:0]      payload_o
);

  logic                 valid_q, valid_d;
  logic [PrioW-1:0]     prio_q, prio_d;
  logic [PAYLOAD_W-1:0] payload_q, payload_d;

  // Keep the entry in place when it stays ahead of the new one
  always_comb begin
    case (op_i)
      SPQ_OP_PRIO: keep_o = valid_q && (prio_q >= new_prio_i);
      SPQ_OP_TAIL: keep_o = valid_q;
      default:     keep_o = 1'b0;
    endcase
  end

  always_comb begin
    valid_d   = valid_q;
    prio_d    = prio_q;
    payload_d = payload_q;
    case (op_i)
      SPQ_OP_PRIO, SPQ_OP_HEAD, SPQ_OP_TAIL: begin
        if (!keep_o) begin
          if (left_keep_i) begin
            valid_d   = 1'b1;
            prio_d    = new_prio_i;
            payload_d = new_payload_i;
          end else begin
            valid_d   = left_valid_i;
            prio_d    = left_prio_i;
            payload_d = left_payload_i;
          end
        end
      end
      SPQ_OP_POP: begin
        valid_d   = right_valid_i;
        prio_d    = right_prio_i;
        payload_d = right_payload_i;
      end
      default: begin
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q    <= prio_d;
    payload_q <= payload_d;
  end

  assign valid_o   = valid_q;
  assign prio_o    = prio_q;
  assign payload_o = payload_q;

endmodule

`default_nettype wire

/* rtl/stable_priority_queue_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Stable bounded priority queue of 32-bit handles, kept front to back in
// descending priority as a chain of QueueDepth cells. Every accepted beat
// is one action: priority insert (placed behind all entries of equal or
// higher priority, so ties leave in arrival order), head insert (front,
// priority PriorityMax), tail insert (end, lowest priority) or get (pop
// the front). Each beat yields exactly one result beat carrying the
// popped handle (zero otherwise), a status (ok, full insert dropped, empty
// get) and the occupancy after the action, truncated to 5 bits. An
// incoming priority above PriorityMax is saturated to it. All cells
// compare against the broadcast priority in parallel and shift by one
// place in the same cycle, so one beat is taken every cycle while the
// held result is not stalled; the single result register lets a new
// beat in while the previous result is being taken. The result beat
// follows in the next cycle. No clearing pass is needed after reset.
module stable_priority_queue_core import spq_pkg::*; #(
  parameter int unsigned QueueDepth  = QUEUE_DEPTH,
  parameter int unsigned PriorityMax = PRIO_CEIL
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire spq_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output spq_out_t      out_data_o
);

  localparam int unsigned PrioW = (PriorityMax < 2) ? 1 : $clog2(PriorityMax + 1);
  localparam int unsigned CntW  = $clog2(QueueDepth + 1);

  logic                 accept;
  logic                 full, empty;
  spq_op_e              op;
  logic [PrioW-1:0]     prio_sat;
  logic [PrioW-1:0]     new_prio;
  logic [CntW-1:0]      count_q, count_d;
  logic                 out_valid_q, out_valid_d;
  spq_out_t             out_data_q, out_data_d;

  logic [QueueDepth-1:0] keep;
  logic [QueueDepth-1:0] valid;
  logic [PrioW-1:0]      prio    [QueueDepth];
  logic [PAYLOAD_W-1:0]  payload [QueueDepth];

  // Take a beat unless the held result is blocked downstream
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Entries stay packed at the front, so the end cells tell full and empty
  assign full  = valid[QueueDepth-1];
  assign empty = !valid[0];

  // Saturate the requested priority to the top of the range
  always_comb begin
    if (32'(in_data_i.priority_req) > 32'(PriorityMax)) begin
      prio_sat = PrioW'(PriorityMax);
    end else begin
      prio_sat = PrioW'(in_data_i.priority_req);
    end
  end

  // Head inserts carry the top priority, tail inserts the bottom one
  always_comb begin
    case (in_data_i.action)
      ACT_HEAD: new_prio = PrioW'(PriorityMax);
      ACT_TAIL: new_prio = PrioW'(PRIO_FLOOR);
      default:  new_prio = prio_sat;
    endcase
  end

  // Decode the beat into the command broadcast down the chain
  always_comb begin
    op = SPQ_OP_HOLD;
    if (accept) begin
      case (in_data_i.action)
        ACT_GET:  op = empty ? SPQ_OP_HOLD : SPQ_OP_POP;
        ACT_HEAD: op = full  ? SPQ_OP_HOLD : SPQ_OP_HEAD;
        ACT_TAIL: op = full  ? SPQ_OP_HOLD : SPQ_OP_TAIL;
        ACT_PRIO: op = full  ? SPQ_OP_HOLD : SPQ_OP_PRIO;
        default:  op = SPQ_OP_HOLD;
      endcase
    end
  end

  genvar g;
  generate
    for (g = 0; g < QueueDepth; g++) begin : g_cell
      logic                 left_keep, left_valid, right_valid;
      logic [PrioW-1:0]     left_prio, right_prio;
      logic [PAYLOAD_W-1:0] left_payload, right_payload;

      if (g == 0) begin : g_first
        // Nothing sits ahead of the front cell
        assign left_keep    = 1'b1;
        assign left_valid   = 1'b0;
        assign left_prio    = '0;
        assign left_payload = '0;
      end else begin : g_mid
        assign left_keep    = keep[g-1];
        assign left_valid   = valid[g-1];
        assign left_prio    = prio[g-1];
        assign left_payload = payload[g-1];
      end

      if (g == QueueDepth - 1) begin : g_last
        // A pop drains an empty slot into the back cell
        assign right_valid   = 1'b0;
        assign right_prio    = '0;
        assign right_payload = '0;
      end else begin : g_body
        assign right_valid   = valid[g+1];
        assign right_prio    = prio[g+1];
        assign right_payload = payload[g+1];
      end

      spq_cell #(
        .PrioW (PrioW)
      ) u_cell (
        .clk_i           (clk_i),
        .rst_ni          (rst_ni),
        .op_i            (op),
        .new_prio_i      (new_prio),
        .new_payload_i   (in_data_i.payload),
        .left_keep_i     (left_keep),
        .left_valid_i    (left_valid),
        .left_prio_i     (left_prio),
        .left_payload_i  (left_payload),
        .right_valid_i   (right_valid),
        .right_prio_i    (right_prio),
        .right_payload_i (right_payload),
        .keep_o          (keep[g]),
        .valid_o         (valid[g]),
        .prio_o          (prio[g]),
        .payload_o       (payload[g])
      );
    end
  endgenerate

  // Track occupancy alongside the chain
  always_comb begin
    case (op)
      SPQ_OP_PRIO, SPQ_OP_HEAD, SPQ_OP_TAIL: count_d = count_q + CntW'(1);
      SPQ_OP_POP:                            count_d = count_q - CntW'(1);
      default:                               count_d = count_q;
    endcase
  end

  // Build the result beat
  always_comb begin
    out_data_d.out_payload = '0;
    out_data_d.status      = ST_OK;
    out_data_d.occupancy   = OCC_W'(count_d);
    if (in_data_i.action == ACT_GET) begin
      if (empty) begin
        out_data_d.status = ST_EMPTY;
      end else begin
        out_data_d.out_payload = payload[0];
      end
    end else if (full) begin
      out_data_d.status = ST_FULL;
    end
  end

  // Load on accept, drop once taken, hold while stalled
  always_comb begin
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

/* tb/sv/stable_priority_queue_core_tb.sv */
`timescale 1ns / 1ps

module stable_priority_queue_core_tb;
  import spq_pkg::*;

  localparam int unsigned CLK_HALF     = 5;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned PHASE_BEATS  = 210;
  localparam int unsigned DRAIN_CYCLES = 8;
  // Cycle limit, set far above what a correct run needs.
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned REPORT_CAP   = 40;

  // Mirror of the queue contents. It applies every accepted request beat,
  // queues the result that beat must produce, and matches result beats
  // against the oldest queued result.
  class queue_mirror;
    logic [REQ_W-1:0]     prio_q[QUEUE_DEPTH];
    logic [PAYLOAD_W-1:0] handle_q[QUEUE_DEPTH];
    int unsigned          fill;
    spq_out_t             pending_results[$];
    int unsigned          failures;

    function new();
      fill     = 0;
      failures = 0;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= REPORT_CAP) begin
        $error("%s", msg);
      end
    endfunction

    function void apply_request(spq_in_t beat);
      spq_out_t         res;
      int unsigned      slot;
      int unsigned      i;
      logic [REQ_W-1:0] prio;
      res        = '0;
      res.status = ST_OK;
      if (beat.action == ACT_GET) begin
        if (fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // Pop the front and close the gap.
          res.out_payload = handle_q[0];
          for (i = 1; i < fill; i++) begin
            prio_q[i-1]   = prio_q[i];
            handle_q[i-1] = handle_q[i];
          end
          fill--;
        end
      end else if (fill >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        case (beat.action)
          ACT_HEAD: begin
            slot = 0;
            prio = REQ_W'(PRIO_CEIL);
          end
          ACT_TAIL: begin
            slot = fill;
            prio = REQ_W'(PRIO_FLOOR);
          end
          default: begin
            // Saturate, then walk past every entry of equal or higher priority.
            prio = (beat.priority_req > PRIO_CEIL) ?
                   REQ_W'(PRIO_CEIL) : beat.priority_req;
            slot = 0;
            while (slot < fill && prio_q[slot] >= prio) begin
              slot++;
            end
          end
        endcase
        for (i = fill; i > slot; i--) begin
          prio_q[i]   = prio_q[i-1];
          handle_q[i] = handle_q[i-1];
        end
        prio_q[slot]   = prio;
        handle_q[slot] = beat.payload;
        fill++;
      end
      res.occupancy = OCC_W'(fill);
      pending_results.push_back(res);
    endfunction

    function void match_result(spq_out_t got);
      spq_out_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result beat: out_payload %h status %0d occupancy %0d",
                         got.out_payload, got.status, got.occupancy));
        return;
      end
      want = pending_results.pop_front();
      if (got.out_payload !== want.out_payload) begin
        report($sformatf("out_payload: expected %h, actual %h",
                         want.out_payload, got.out_payload));
      end
      if (got.status !== want.status) begin
        report($sformatf("status: expected %0d, actual %0d", want.status, got.status));
      end
      if (got.occupancy !== want.occupancy) begin
        report($sformatf("occupancy: expected %0d, actual %0d",
                         want.occupancy, got.occupancy));
      end
    endfunction
  endclass

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  spq_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  spq_out_t out_data_o;

  queue_mirror mirror = new();

  // Idle and stall rates in percent, changed per phase.
  int unsigned in_idle_pct   = 0;
  int unsigned out_stall_pct = 0;
  int unsigned cycle_count   = 0;

  stable_priority_queue_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Stall the result side at random, independent of out_valid_o.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  // Sample both handshakes at the edge: apply the request first so that a
  // result sampled at the same edge would still find its expectation queued.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        mirror.apply_request(in_data_i);
      end
      if (out_valid_o && !out_stall_i) begin
        mirror.match_result(out_data_o);
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("stable_priority_queue_core verification failed");
      $finish;
    end
  end

  function automatic spq_in_t make_beat(logic [ACTION_W-1:0] action,
                                        logic [PAYLOAD_W-1:0] payload,
                                        logic [REQ_W-1:0] prio);
    spq_in_t beat;
    beat.action       = action;
    beat.payload      = payload;
    beat.priority_req = prio;
    return beat;
  endfunction

  // Idle at random, then present the beat and hold it until taken. Returns
  // on the accepting edge, so a following call may keep valid high.
  task automatic send_beat(spq_in_t beat);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
  endtask

  // Empty get, ties, extremes, head and tail inserts, fill to full, a dropped
  // head insert and a dropped tail insert on a full queue, then a few pops.
  task automatic run_directed();
    int unsigned n;
    send_beat(make_beat(ACT_GET,  32'hFFFF_FFFF, 8'hFF));
    send_beat(make_beat(ACT_PRIO, 32'h0000_0000, 8'd128));
    send_beat(make_beat(ACT_PRIO, 32'h0000_0001, 8'd128));
    send_beat(make_beat(ACT_PRIO, 32'h0000_0002, 8'd128));
    send_beat(make_beat(ACT_PRIO, 32'hFFFF_FFFF, 8'hFF));
    send_beat(make_beat(ACT_PRIO, 32'h0000_0010, 8'h00));
    send_beat(make_beat(ACT_HEAD, 32'hA5A5_A5A5, 8'h00));
    send_beat(make_beat(ACT_TAIL, 32'h5A5A_5A5A, 8'hFF));
    send_beat(make_beat(ACT_PRIO, 32'h0000_0003, 8'hFF));
    send_beat(make_beat(ACT_PRIO, 32'h0000_0004, 8'h00));
    for (n = 0; n < QUEUE_DEPTH - 10; n++) begin
      send_beat(make_beat(ACT_PRIO, $urandom, 8'($urandom)));
    end
    send_beat(make_beat(ACT_PRIO, 32'h1111_1111, 8'hFF));
    send_beat(make_beat(ACT_HEAD, 32'h2222_2222, 8'h80));
    send_beat(make_beat(ACT_TAIL, 32'h3333_3333, 8'h01));
    for (n = 0; n < 4; n++) begin
      send_beat(make_beat(ACT_GET, $urandom, 8'($urandom)));
    end
  endtask

  // Bursts that lean toward filling, draining or neither, so the queue
  // swings between empty and full. Priorities often come from a small set
  // to force ties.
  task automatic run_random(int unsigned count);
    int unsigned      sent;
    int unsigned      burst;
    int unsigned      get_pct;
    int unsigned      pick;
    logic [ACTION_W-1:0] action;
    logic [REQ_W-1:0] prio;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(24, 1);
      case ($urandom_range(2))
        0:       get_pct = 15;
        1:       get_pct = 75;
        default: get_pct = 45;
      endcase
      while (burst != 0 && sent < count) begin
        pick = $urandom_range(99);
        if (pick < get_pct) begin
          action = ACT_GET;
        end else if (pick < get_pct + (100 - get_pct) / 8) begin
          action = ACT_HEAD;
        end else if (pick < get_pct + (100 - get_pct) / 4) begin
          action = ACT_TAIL;
        end else begin
          action = ACT_PRIO;
        end
        if ($urandom_range(1) == 0) begin
          prio = 8'($urandom_range(3) * 85);
        end else begin
          prio = 8'($urandom);
        end
        send_beat(make_beat(action, $urandom, prio));
        burst--;
        sent++;
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Full rate on both sides first.
    in_idle_pct   = 0;
    out_stall_pct = 0;
    run_directed();
    run_random(PHASE_BEATS);

    // Sparse sender.
    in_idle_pct   = 65;
    out_stall_pct = 0;
    run_random(PHASE_BEATS);

    // Sluggish receiver.
    in_idle_pct   = 0;
    out_stall_pct = 65;
    run_random(PHASE_BEATS);

    // Light idling on both sides.
    in_idle_pct   = 9;
    out_stall_pct = 9;
    run_random(PHASE_BEATS);

    in_valid_i <= 1'b0;
    while (mirror.pending() != 0) begin
      @(posedge clk_i);
    end
    // Catch any stray result beat.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mirror.failures == 0) begin
      $display("stable_priority_queue_core verification clean");
    end else begin
      $display("stable_priority_queue_core verification failed");
    end
    $finish;
  end

endmodule
